>>> sv/spmbs_pkg.sv
// ----------------------------------------------------------------------------
// spmbs_pkg
// Shared types and constants for the SPI master byte shifter.
// ----------------------------------------------------------------------------
package spmbs_pkg;

  localparam int unsigned BitsPerWord = 8;
  localparam int unsigned DivWidth    = 16;
  localparam int unsigned HalfWidth   = $clog2(2 * BitsPerWord);
  localparam int unsigned PosWidth    = $clog2(BitsPerWord);
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = DivWidth;
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CLOCK_MODE  = 2'd0,
    REG_LSB_FIRST   = 2'd1,
    REG_HALF_PERIOD = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  // input op codes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    logic [BitsPerWord-1:0] rx_byte;
    logic                   done_res;
    logic                   busy_res;
    logic                   mosi;
    logic                   sck;
  } res_t;

endpackage

>>> sv/spmbs_core.sv
// ----------------------------------------------------------------------------
// spmbs_core
// Bit timing, shift registers and configuration for one SPI byte transfer.
// ----------------------------------------------------------------------------
module spmbs_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  spmbs_pkg::op_t                         op,
  input  logic [spmbs_pkg::BitsPerWord-1:0]      tx_byte,
  input  logic                                   miso,
  input  logic                                   cfg_we,
  input  logic [spmbs_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [spmbs_pkg::CfgWidth-1:0]         cfg_wdata,
  output spmbs_pkg::res_t                        res
);

  logic [1:0]                          mode_r;
  logic                                lsb_r;
  logic [spmbs_pkg::DivWidth-1:0]      hp_r;

  logic                                active_r, active_nxt;
  logic [spmbs_pkg::DivWidth-1:0]      tick_r, tick_nxt;
  logic [spmbs_pkg::HalfWidth-1:0]     half_r, half_nxt;
  logic [spmbs_pkg::BitsPerWord-1:0]   send_r, send_nxt;
  logic [spmbs_pkg::BitsPerWord-1:0]   recv_r, recv_nxt;
  logic                                clk_lvl_r, clk_lvl_nxt;
  logic                                data_r, data_nxt;

  logic                                cpha, idle_lvl;
  logic [spmbs_pkg::DivWidth-1:0]      hp_eff, tick_inc;
  logic [spmbs_pkg::HalfWidth-1:0]     half_inc;
  logic [spmbs_pkg::PosWidth-1:0]      pos_cur, pos_inc, pos_first;
  logic                                done;
  logic [spmbs_pkg::BitsPerWord-1:0]   rx;
  logic [spmbs_pkg::BitsPerWord-1:0]   recv_bit;

  assign cpha     = mode_r[0];
  assign idle_lvl = mode_r[1];
  assign hp_eff   = (hp_r == '0) ? spmbs_pkg::DivWidth'(1) : hp_r;
  assign tick_inc = tick_r + spmbs_pkg::DivWidth'(1);
  assign half_inc = half_r + spmbs_pkg::HalfWidth'(1);
  // bit k of the word: k itself for LSB first, BitsPerWord-1-k otherwise
  assign pos_cur  = lsb_r ? half_r[spmbs_pkg::HalfWidth-1:1]
                          : ~half_r[spmbs_pkg::HalfWidth-1:1];
  assign pos_inc  = lsb_r ? half_inc[spmbs_pkg::HalfWidth-1:1]
                          : ~half_inc[spmbs_pkg::HalfWidth-1:1];
  assign pos_first = lsb_r ? '0 : '1;
  assign recv_bit = spmbs_pkg::BitsPerWord'(miso) << pos_cur;

  always_comb begin
    active_nxt  = active_r;
    tick_nxt    = tick_r;
    half_nxt    = half_r;
    send_nxt    = send_r;
    recv_nxt    = recv_r;
    clk_lvl_nxt = clk_lvl_r;
    data_nxt    = data_r;
    done        = 1'b0;
    rx          = '0;
    if (step) begin
      if (op == spmbs_pkg::OP_START) begin
        if (!active_r) begin
          send_nxt   = tx_byte;
          recv_nxt   = '0;
          half_nxt   = '0;
          tick_nxt   = '0;
          active_nxt = 1'b1;
          data_nxt   = tx_byte[pos_first];
          if (cpha) begin
            clk_lvl_nxt = ~idle_lvl;
          end
        end
      end else if (active_r) begin
        tick_nxt = tick_inc;
        if (tick_inc >= hp_eff) begin
          tick_nxt = '0;
          if (!half_r[0]) begin
            clk_lvl_nxt = cpha ? idle_lvl : ~idle_lvl;
            recv_nxt    = recv_r | recv_bit;
          end else if (!cpha) begin
            clk_lvl_nxt = idle_lvl;
          end
          if (half_r == '1) begin
            active_nxt = 1'b0;
            half_nxt   = '0;
            done       = 1'b1;
            rx         = recv_r;
          end else begin
            half_nxt = half_inc;
            // next bit opens on an even half
            if (!half_inc[0]) begin
              data_nxt = send_r[pos_inc];
              if (cpha) begin
                clk_lvl_nxt = ~idle_lvl;
              end
            end
          end
        end
      end
    end
    // idle clock follows a mode write
    if (cfg_we && cfg_index == spmbs_pkg::REG_CLOCK_MODE && !active_r) begin
      clk_lvl_nxt = cfg_wdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      lsb_r     <= 1'b0;
      hp_r      <= spmbs_pkg::DivWidth'(1);
      active_r  <= 1'b0;
      tick_r    <= '0;
      half_r    <= '0;
      send_r    <= '0;
      recv_r    <= '0;
      clk_lvl_r <= 1'b0;
      data_r    <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      tick_r    <= tick_nxt;
      half_r    <= half_nxt;
      send_r    <= send_nxt;
      recv_r    <= recv_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      data_r    <= data_nxt;
      if (cfg_we) begin
        case (cfg_index)
          spmbs_pkg::REG_CLOCK_MODE:  mode_r <= cfg_wdata[1:0];
          spmbs_pkg::REG_LSB_FIRST:   lsb_r  <= cfg_wdata[0];
          spmbs_pkg::REG_HALF_PERIOD: hp_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign res.sck      = clk_lvl_nxt;
  assign res.mosi     = data_nxt;
  assign res.busy_res = active_nxt;
  assign res.done_res = done;
  assign res.rx_byte  = rx;

`ifndef ASSERT_OFF
  a_idle_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> half_r == '0)
    else $error("half index nonzero while idle");

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> tick_r == '0)
    else $error("tick count nonzero while idle");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> !active_r)
    else $error("transfer still active after done");

  a_tick_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && !active_r && op == spmbs_pkg::OP_TICK |=> $stable(send_r) && $stable(data_r))
    else $error("idle tick changed state");
`endif

endmodule

>>> sv/spi_master_byte_shifter_top.sv
// ----------------------------------------------------------------------------
// spi_master_byte_shifter_top
// SPI master byte shifter, clock modes 0 to 3, MSB or LSB first.
// Each accepted word's result is registered in main, or in skid while main stalls; out_tvalid shows main.
// Throughput: one word per cycle while in_tready is high; state is updated in the accepting cycle.
// A two-entry output register (main plus skid) keeps in_tready high while only main holds a waiting result.
// Reset: synchronous, active low; clears state, output queue, clock mode and bit order; half period resets to 1.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [spmbs_pkg::InDataWidth-1:0]      in_tdata,   // tx_byte[7:0], miso[8]
  input  logic                                   in_tuser,   // op
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [spmbs_pkg::OutDataWidth-1:0]     out_tdata,  // sck, mosi, busy_res,
                                                             // done_res, rx_byte[11:4]
  input  logic                                   cfg_we,
  input  logic [spmbs_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [spmbs_pkg::CfgWidth-1:0]         cfg_wdata
);

  logic            in_fire;
  spmbs_pkg::res_t res;
  spmbs_pkg::res_t main_r, skid_r;
  logic            main_vld_r, skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;

  spmbs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .op        (spmbs_pkg::op_t'(in_tuser)),
    .tx_byte   (in_tdata[spmbs_pkg::BitsPerWord-1:0]),
    .miso      (in_tdata[spmbs_pkg::BitsPerWord]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_tready || !main_vld_r) begin
      if (skid_vld_r) begin
        main_r     <= skid_r;
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_r     <= res;
        main_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_r     <= res;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = main_vld_r;
  assign out_tdata  = spmbs_pkg::OutDataWidth'(main_r);

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid holds a word while main is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> main_vld_r)
    else $error("accepted word not queued");
`endif

endmodule
